// ===== design/tccs_pkg.sv =====
// shared types, sizes and codes for the text console with cursor and scroll
// no dependencies; imported by text_console_cursor_scroll
`default_nettype none

package tccs_pkg;

   // screen geometry
   localparam int ROWS      = 25;
   localparam int COLS      = 80;
   localparam int TAB_WIDTH = 4;

   localparam int CELLS     = ROWS * COLS;
   localparam int COPY_N    = (ROWS - 1) * COLS;
   localparam int ROW_W     = $clog2(ROWS);
   localparam int COL_W     = $clog2(COLS);
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int SWEEP_W   = $clog2(CELLS + 1);
   localparam int TAB_CNT_W = $clog2(TAB_WIDTH + 1);
   localparam int CELL_W    = 16;

   // character and attribute codes
   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_BLANK   = 8'h00;
   localparam logic [7:0] ATTR_RESET = 8'h0f;

   typedef logic [ROW_W-1:0]     row_type;
   typedef logic [COL_W-1:0]     col_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [SWEEP_W-1:0]   sweep_type;
   typedef logic [TAB_CNT_W-1:0] tab_cnt_type;

   typedef struct packed {
      logic [7:0] attr;
      logic [7:0] chr;
   } cell_type;

   typedef enum logic [1:0] {
      MODE_PUT    = 2'd0,
      MODE_CLEAR  = 2'd1,
      MODE_SETCUR = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_PUT_WR,
      S_SCROLL,
      S_FILL,
      S_CLEAR,
      S_DONE
   } state_type;

   // linear cell address of a row and column
   function automatic addr_type cell_addr(input row_type r, input col_type c);
      addr_type base;
      base = addr_type'(addr_type'(r) * addr_type'(COLS));
      return addr_type'(base + addr_type'(c));
   endfunction

endpackage

`default_nettype wire

// ===== design/tccs_ram.sv =====
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/text_console_cursor_scroll.sv =====
// text console engine: cell store in one ram, cursor, scroll and clear sequencer
// depends on tccs_pkg and tccs_ram
//
//   port group  dir  handshake            word
//   req_*       in   req_valid/req_stall  mode, char_code, color, use_color, row, col
//   rsp_*       out  rsp_valid/rsp_stall  cursor_row, cursor_col, read_char, read_attr
//
// one item at a time; a word is decoded in S_EXEC, where a put also reads the old
// attribute at the cursor, and S_PUT_WR writes the cell; a tab repeats both per space.
// a scroll copies each row one row up and fills the last row (one copied or filled
// cell per cycle), a clear sweeps every cell. after reset a clearing pass runs with
// req_stall high. results sit in an output register; a stalled result holds the
// sequencer in its last step and the next word is not taken while it waits.
`default_nettype none

module text_console_cursor_scroll (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tccs_pkg::mode_type req_mode,
   input  wire logic [7:0]        req_char_code,
   input  wire logic [7:0]        req_color,
   input  wire logic              req_use_color,
   input  wire logic [7:0]        req_row,
   input  wire logic [7:0]        req_col,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [4:0]             rsp_cursor_row,
   output logic [6:0]             rsp_cursor_col,
   output logic [7:0]             rsp_read_char,
   output logic [7:0]             rsp_read_attr
);

   import tccs_pkg::*;

   state_type   state_ff, state_in;
   sweep_type   sweep_ff, sweep_in;
   row_type     cur_row_ff, cur_row_in;
   col_type     cur_col_ff, cur_col_in;
   logic [7:0]  fill_ff, fill_in;
   tab_cnt_type tab_cnt_ff, tab_cnt_in;

   mode_type    mode_ff;
   logic [7:0]  char_ff;
   logic [7:0]  color_ff;
   logic        use_color_ff;
   row_type     trow_ff;
   col_type     tcol_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  rsp_row_ff;
   logic [6:0]  rsp_col_ff;
   logic [7:0]  rsp_char_ff;
   logic [7:0]  rsp_attr_ff;

   logic        wr_en;
   addr_type    wr_addr;
   cell_type    wr_cell;
   logic        rd_en;
   addr_type    rd_addr;
   logic [CELL_W-1:0] rd_data;
   cell_type    rd_cell;

   logic        accept;
   logic        rsp_free;
   logic        load_rsp;
   logic        is_tab;
   logic        is_newline;
   logic        more_tab;
   logic        row_last;
   logic        col_last;
   row_type     req_row_clamp;
   col_type     req_col_clamp;
   addr_type    cursor_addr;

   tccs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_cell),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_cell = cell_type'(rd_data);

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = (state_ff == S_DONE) && rsp_free;

   assign req_row_clamp = (req_row >= 8'(ROWS - 1)) ? row_type'(ROWS - 1)
                                                    : row_type'(req_row);
   assign req_col_clamp = (req_col >= 8'(COLS - 1)) ? col_type'(COLS - 1)
                                                    : col_type'(req_col);

   assign is_tab      = (char_ff == CH_TAB);
   assign is_newline  = (char_ff == CH_NEWLINE);
   assign row_last    = (cur_row_ff >= row_type'(ROWS - 1));
   assign col_last    = (cur_col_ff >= col_type'(COLS - 1));
   assign cursor_addr = cell_addr(cur_row_ff, cur_col_ff);
   // another space of the tab still to go, counted after this step
   assign more_tab    = (mode_ff == MODE_PUT) && is_tab &&
                        (tab_cnt_in != tab_cnt_type'(TAB_WIDTH));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            if (sweep_ff == sweep_type'(CELLS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (mode_ff)
               MODE_PUT: begin
                  if (!is_newline) state_in = S_PUT_WR;
                  else if (row_last) state_in = S_SCROLL;
                  else state_in = S_DONE;
               end
               MODE_CLEAR:  state_in = S_CLEAR;
               MODE_SETCUR: state_in = S_DONE;
               MODE_READ:   state_in = S_DONE;
               default:     state_in = S_DONE;
            endcase
         end
         S_PUT_WR: begin
            if (col_last && row_last) state_in = S_SCROLL;
            else if (more_tab) state_in = S_EXEC;
            else state_in = S_DONE;
         end
         S_SCROLL: begin
            if (sweep_ff == sweep_type'(COPY_N)) state_in = S_FILL;
         end
         S_FILL: begin
            if (sweep_ff == sweep_type'(CELLS)) begin
               state_in = more_tab ? S_EXEC : S_DONE;
            end
         end
         S_CLEAR: begin
            if (sweep_ff == sweep_type'(CELLS - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      sweep_in     = '0;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      fill_in      = fill_ff;
      tab_cnt_in   = tab_cnt_ff;
      wr_en        = 1'b0;
      wr_addr      = cursor_addr;
      wr_cell      = '{attr: fill_ff, chr: CH_BLANK};
      rd_en        = 1'b0;
      rd_addr      = cursor_addr;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_INIT, S_CLEAR: begin
            // clearing sweep, one cell per cycle
            sweep_in = sweep_type'(sweep_ff + 1'b1);
            wr_en    = 1'b1;
            wr_addr  = addr_type'(sweep_ff);
         end
         S_IDLE: begin
            if (accept) tab_cnt_in = '0;
         end
         S_EXEC: begin
            unique case (mode_ff)
               MODE_PUT: begin
                  if (is_newline) begin
                     cur_col_in = '0;
                     cur_row_in = row_last ? row_type'(ROWS - 1)
                                           : row_type'(cur_row_ff + 1'b1);
                  end else begin
                     // fetch the old attribute at the cursor
                     rd_en = 1'b1;
                  end
               end
               MODE_CLEAR: begin
                  if (use_color_ff) fill_in = color_ff;
               end
               MODE_SETCUR: begin
                  cur_row_in = trow_ff;
                  cur_col_in = tcol_ff;
               end
               MODE_READ: begin
                  rd_en   = 1'b1;
                  rd_addr = cell_addr(trow_ff, tcol_ff);
               end
               default: ;
            endcase
         end
         S_PUT_WR: begin
            wr_en        = 1'b1;
            wr_cell.chr  = is_tab ? CH_SPACE : char_ff;
            wr_cell.attr = (use_color_ff && !is_tab) ? color_ff : rd_cell.attr;
            tab_cnt_in   = tab_cnt_type'(tab_cnt_ff + 1'b1);
            if (col_last) begin
               cur_col_in = '0;
               cur_row_in = row_last ? row_type'(ROWS - 1)
                                     : row_type'(cur_row_ff + 1'b1);
            end else begin
               cur_col_in = col_type'(cur_col_ff + 1'b1);
            end
         end
         S_SCROLL: begin
            // read one row ahead, write the word read last cycle one row up
            sweep_in = sweep_type'(sweep_ff + 1'b1);
            rd_en    = (sweep_ff != sweep_type'(COPY_N));
            rd_addr  = addr_type'(sweep_ff + sweep_type'(COLS));
            wr_en    = (sweep_ff != '0);
            wr_addr  = addr_type'(sweep_ff - 1'b1);
            wr_cell  = rd_cell;
         end
         S_FILL: begin
            sweep_in = sweep_type'(sweep_ff + 1'b1);
            wr_en    = 1'b1;
            wr_addr  = addr_type'(sweep_ff - 1'b1);
         end
         S_DONE: begin
            if (rsp_free) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         fill_ff      <= ATTR_RESET;
         tab_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         fill_ff      <= fill_in;
         tab_cnt_ff   <= tab_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff      <= req_mode;
         char_ff      <= req_char_code;
         color_ff     <= req_color;
         use_color_ff <= req_use_color;
         trow_ff      <= req_row_clamp;
         tcol_ff      <= req_col_clamp;
      end
      if (load_rsp) begin
         rsp_row_ff  <= 5'(cur_row_ff);
         rsp_col_ff  <= 7'(cur_col_ff);
         rsp_char_ff <= (mode_ff == MODE_READ) ? rd_cell.chr : 8'h00;
         rsp_attr_ff <= (mode_ff == MODE_READ) ? rd_cell.attr : 8'h00;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_read_char  = rsp_char_ff;
   assign rsp_read_attr  = rsp_attr_ff;

endmodule

`default_nettype wire

// ===== bench/text_console_cursor_scroll_tb.sv =====
// testbench for text_console_cursor_scroll: directed and random console words,
// checked against an in-bench screen model. depends on tccs_pkg and the design.
`default_nettype none

module text_console_cursor_scroll_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tccs_pkg::*;

   typedef struct {
      mode_type   mode;
      logic [7:0] char_code;
      logic [7:0] color;
      logic       use_color;
      logic [7:0] row;
      logic [7:0] col;
   } console_cmd_type;

   typedef struct packed {
      logic [4:0] crow;
      logic [6:0] ccol;
      logic [7:0] rchar;
      logic [7:0] rattr;
   } status_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   mode_type   req_mode      = MODE_READ;
   logic [7:0] req_char_code = 8'h00;
   logic [7:0] req_color     = 8'h00;
   logic       req_use_color = 1'b0;
   logic [7:0] req_row       = 8'h00;
   logic [7:0] req_col       = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic [4:0] rsp_cursor_row;
   logic [6:0] rsp_cursor_col;
   logic [7:0] rsp_read_char;
   logic [7:0] rsp_read_attr;

   always #5 clock = ~clock;

   text_console_cursor_scroll u_top (.*);

   // screen model
   cell_type    screen_cells [CELLS];
   int unsigned cur_row;
   int unsigned cur_col;
   logic [7:0]  fill_attr;

   status_type  pending_status [$];
   int unsigned mismatches = 0;
   bit          req_calm   = 1'b0;
   bit          rsp_calm   = 1'b0;

   function automatic void reset_screen();
      int i;
      for (i = 0; i < CELLS; i++) screen_cells[i] = '{attr: ATTR_RESET, chr: CH_BLANK};
      cur_row   = 0;
      cur_col   = 0;
      fill_attr = ATTR_RESET;
   endfunction

   function automatic void scroll_screen();
      int i;
      for (i = 0; i < COPY_N; i++) screen_cells[i] = screen_cells[i + COLS];
      for (i = COPY_N; i < CELLS; i++) screen_cells[i] = '{attr: fill_attr, chr: CH_BLANK};
   endfunction

   function automatic void next_line();
      cur_col = 0;
      if (cur_row + 1 >= ROWS) begin
         scroll_screen();
         cur_row = ROWS - 1;
      end else begin
         cur_row++;
      end
   endfunction

   function automatic void write_and_advance(input logic [7:0] ch, input logic with_attr,
                                             input logic [7:0] attr);
      int idx;
      idx = cur_row * COLS + cur_col;
      screen_cells[idx].chr = ch;
      if (with_attr) screen_cells[idx].attr = attr;
      if (cur_col + 1 >= COLS) next_line();
      else cur_col++;
   endfunction

   function automatic int unsigned clamp_to(input logic [7:0] v, input int unsigned top);
      return (v > top) ? top : int'(v);
   endfunction

   function automatic status_type predict_status(input console_cmd_type cmd);
      status_type  st;
      int unsigned r;
      int unsigned c;
      int          i;
      st = '0;
      r  = clamp_to(cmd.row, ROWS - 1);
      c  = clamp_to(cmd.col, COLS - 1);
      case (cmd.mode)
         MODE_PUT: begin
            if (cmd.char_code == CH_NEWLINE) begin
               next_line();
            end else if (cmd.char_code == CH_TAB) begin
               // tab never writes an attribute
               for (i = 0; i < TAB_WIDTH; i++) write_and_advance(CH_SPACE, 1'b0, 8'h00);
            end else begin
               write_and_advance(cmd.char_code, cmd.use_color, cmd.color);
            end
         end
         MODE_CLEAR: begin
            if (cmd.use_color) fill_attr = cmd.color;
            for (i = 0; i < CELLS; i++) screen_cells[i] = '{attr: fill_attr, chr: CH_BLANK};
         end
         MODE_SETCUR: begin
            cur_row = r;
            cur_col = c;
         end
         MODE_READ: begin
            st.rchar = screen_cells[r * COLS + c].chr;
            st.rattr = screen_cells[r * COLS + c].attr;
         end
      endcase
      st.crow = 5'(cur_row);
      st.ccol = 7'(cur_col);
      return st;
   endfunction

   task automatic send_cmd(input console_cmd_type cmd);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 49) == 0) req_calm = ~req_calm;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= cmd.mode;
      req_char_code <= cmd.char_code;
      req_color     <= cmd.color;
      req_use_color <= cmd.use_color;
      req_row       <= cmd.row;
      req_col       <= cmd.col;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_status.push_back(predict_status(cmd));
   endtask

   // fields that a mode ignores get random values
   task automatic put_char(input logic [7:0] ch, input logic [7:0] color, input logic use_color);
      console_cmd_type cmd;
      cmd = '{MODE_PUT, ch, color, use_color, 8'($urandom), 8'($urandom)};
      send_cmd(cmd);
   endtask

   task automatic clear_screen(input logic [7:0] color, input logic use_color);
      console_cmd_type cmd;
      cmd = '{MODE_CLEAR, 8'($urandom), color, use_color, 8'($urandom), 8'($urandom)};
      send_cmd(cmd);
   endtask

   task automatic set_cursor(input logic [7:0] r, input logic [7:0] c);
      console_cmd_type cmd;
      cmd = '{MODE_SETCUR, 8'($urandom), 8'($urandom), 1'($urandom), r, c};
      send_cmd(cmd);
   endtask

   task automatic read_cell(input logic [7:0] r, input logic [7:0] c);
      console_cmd_type cmd;
      cmd = '{MODE_READ, 8'($urandom), 8'($urandom), 1'($urandom), r, c};
      send_cmd(cmd);
   endtask

   task automatic test_reset_state();
      read_cell(0, 0);
      read_cell(255, 255);
      set_cursor(200, 128);
      read_cell(13, 40);
   endtask

   task automatic test_put_and_wrap();
      set_cursor(0, 0);
      put_char(8'hff, 8'h00, 1'b1);
      put_char(8'h00, 8'hff, 1'b1);
      put_char(8'h41, 8'haa, 1'b0);
      read_cell(0, 1);
      set_cursor(3, 8'(COLS - 2));
      put_char(8'h78, 8'h3c, 1'b1);
      put_char(8'h79, 8'hc3, 1'b1);
      read_cell(3, 8'(COLS - 1));
   endtask

   task automatic test_newline_tab();
      put_char(CH_NEWLINE, 8'hff, 1'b1);
      put_char(CH_TAB, 8'h55, 1'b1);
      set_cursor(5, 8'(COLS - 2));
      put_char(CH_TAB, 8'h00, 1'b0);
      read_cell(6, 1);
   endtask

   task automatic test_scroll();
      set_cursor(8'(ROWS - 1), 8'(COLS - 1));
      put_char(8'h5a, 8'h5a, 1'b1);
      read_cell(8'(ROWS - 2), 8'(COLS - 1));
      put_char(CH_NEWLINE, 8'h00, 1'b0);
      set_cursor(8'(ROWS - 1), 8'(COLS - 3));
      put_char(CH_TAB, 8'hee, 1'b1);
      read_cell(8'(ROWS - 2), 8'(COLS - 2));
   endtask

   task automatic test_clear();
      clear_screen(8'hff, 1'b0);
      clear_screen(8'hc3, 1'b1);
      read_cell(7, 7);
      clear_screen(8'h00, 1'b1);
      put_char(CH_NEWLINE, 8'h00, 1'b0);
   endtask

   // mostly in-range targets, some with the upper bits set
   function automatic logic [7:0] pick_row();
      return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, ROWS - 1));
   endfunction

   function automatic logic [7:0] pick_col();
      return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, COLS - 1));
   endfunction

   task automatic test_random(input int count);
      int         n;
      int         pick;
      int         kind;
      logic [7:0] ch;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) ch = CH_NEWLINE;
            else if (kind < 16) ch = CH_TAB;
            else ch = 8'($urandom_range(0, 255));
            put_char(ch, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else if (pick < 57) begin
            clear_screen(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else if (pick < 72) begin
            // park near the end of the last row now and then to force scrolls
            if ($urandom_range(0, 4) == 0)
               set_cursor(8'(ROWS - 1), 8'(COLS - 1 - $urandom_range(0, 5)));
            else
               set_cursor(pick_row(), pick_col());
         end else begin
            read_cell(pick_row(), pick_col());
         end
      end
   endtask

   // result side: random stall after each word, compare against the oldest prediction
   initial begin
      status_type got;
      status_type want;
      int         hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            got = {rsp_cursor_row, rsp_cursor_col, rsp_read_char, rsp_read_attr};
            if (pending_status.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: row %0d col %0d char %02h attr %02h",
                           got.crow, got.ccol, got.rchar, got.rattr);
            end else begin
               want = pending_status.pop_front();
               if (got.crow !== want.crow || got.ccol !== want.ccol ||
                   got.rchar !== want.rchar || got.rattr !== want.rattr) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("mismatch: expected row %0d col %0d char %02h attr %02h, ",
                            want.crow, want.ccol, want.rchar, want.rattr);
                     $display("got row %0d col %0d char %02h attr %02h",
                              got.crow, got.ccol, got.rchar, got.rattr);
                  end
               end
            end
            hold = rsp_calm ? 0 : $urandom_range(0, 4);
            if ($urandom_range(0, 49) == 0) rsp_calm = ~rsp_calm;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      reset_screen();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_put_and_wrap();
      test_newline_tab();
      test_scroll();
      test_clear();
      test_random(1500);
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_status.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/tccs_pkg.sv
design/tccs_ram.sv
design/text_console_cursor_scroll.sv
bench/text_console_cursor_scroll_tb.sv
